FILE: rtl/gcode_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// gcode_token_lexer_assert
// assertion macros used by the lexer top level
// ----------------------------------------------------------------------------
`ifndef GCODE_TOKEN_LEXER_ASSERT_SVH
`define GCODE_TOKEN_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define GTL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcode_token_lexer: implication check failed");
`define GTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcode_token_lexer: next-cycle check failed");
`else
`define GTL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg
// types, character codes and helpers for the g-code token lexer
// ----------------------------------------------------------------------------
`default_nettype none

package gtl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_LDOT,
        MODE_ID,
        MODE_CMT,
        MODE_PAREN,
        MODE_STAR
    } lex_mode_t;

    typedef enum logic [4:0] {
        TOK_NUM,
        TOK_DOT,
        TOK_ID,
        TOK_CMT,
        TOK_PAREN,
        TOK_ADD,
        TOK_SUB,
        TOK_MUL,
        TOK_DIV,
        TOK_POW,
        TOK_OBR,
        TOK_CBR,
        TOK_OANG,
        TOK_CANG,
        TOK_EQ,
        TOK_POUND,
        TOK_EOL,
        TOK_EOF,
        TOK_ERR
    } tok_t;

    typedef struct packed {
        tok_t       token_type;
        logic [7:0] value_char;
        logic       char_valid;
        logic       token_last;
    } result_t;

    // results produced by one input item, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_pair_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_POUND  = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_RBRK   = 8'h5d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_idch(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == CH_UNDER);
    endfunction

    function automatic result_t mk_res(input tok_t t, input logic [7:0] c,
                                       input logic v, input logic l);
        result_t r;
        r.token_type = t;
        r.value_char = v ? c : 8'h00;
        r.char_valid = v;
        r.token_last = l;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gtl_lex.sv
// ----------------------------------------------------------------------------
// gtl_lex
// input register, lexer mode state and the per-byte token decision
// ----------------------------------------------------------------------------
`default_nettype none

module gtl_lex
    import gtl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] ch,
    input  wire logic       room,
    output res_pair_t       res
);

    logic       hold_valid_reg, hold_valid_next;
    logic       req_reg;
    logic [7:0] ch_reg;
    lex_mode_t  mode_reg, mode_next;
    logic       dot_reg, dot_next;
    logic       advance;

    // byte lexed from the idle mode
    logic       idle_v;
    result_t    idle_r;
    lex_mode_t  idle_mode;
    logic       idle_dot;

    logic       fv, sv, take_idle;
    result_t    fr, sr;

    assign advance  = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || room;
    assign hold_valid_next = in_ready ? in_valid : hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            mode_reg       <= MODE_IDLE;
            dot_reg        <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            mode_reg       <= mode_next;
            dot_reg        <= dot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_type;
            ch_reg  <= ch;
        end
    end

    // how a byte starts fresh between tokens
    always_comb
    begin
        idle_v    = 1'b1;
        idle_mode = MODE_IDLE;
        idle_dot  = 1'b0;
        idle_r    = mk_res(TOK_ERR, ch_reg, 1'b1, 1'b1);
        priority if (is_ws(ch_reg) || ch_reg == CH_PCT)
            idle_v = 1'b0;
        else if (ch_reg == CH_NUL)
            idle_r = mk_res(TOK_EOF, CH_NUL, 1'b0, 1'b1);
        else if (ch_reg == CH_SEMI)
        begin
            idle_v    = 1'b0;
            idle_mode = MODE_CMT;
        end
        else if (ch_reg == CH_LPAREN)
        begin
            idle_v    = 1'b0;
            idle_mode = MODE_PAREN;
        end
        else if (ch_reg == CH_DOT)
        begin
            idle_v    = 1'b0;
            idle_mode = MODE_LDOT;
            idle_dot  = 1'b1;
        end
        else if (is_digit(ch_reg))
        begin
            idle_r    = mk_res(TOK_NUM, ch_reg, 1'b1, 1'b0);
            idle_mode = MODE_NUM;
        end
        else if (is_idch(ch_reg))
        begin
            idle_r    = mk_res(TOK_ID, ch_reg, 1'b1, 1'b0);
            idle_mode = MODE_ID;
        end
        else if (ch_reg == CH_STAR)
        begin
            idle_v    = 1'b0;
            idle_mode = MODE_STAR;
        end
        else if (ch_reg == CH_PLUS)
            idle_r = mk_res(TOK_ADD, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_MINUS)
            idle_r = mk_res(TOK_SUB, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_SLASH)
            idle_r = mk_res(TOK_DIV, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_LBRK)
            idle_r = mk_res(TOK_OBR, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_RBRK)
            idle_r = mk_res(TOK_CBR, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_LT)
            idle_r = mk_res(TOK_OANG, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_GT)
            idle_r = mk_res(TOK_CANG, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_EQ)
            idle_r = mk_res(TOK_EQ, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_POUND)
            idle_r = mk_res(TOK_POUND, ch_reg, 1'b1, 1'b1);
        else if (ch_reg == CH_LF)
            idle_r = mk_res(TOK_EOL, ch_reg, 1'b1, 1'b1);
        else
            idle_r = mk_res(TOK_ERR, ch_reg, 1'b1, 1'b1);
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        dot_next  = dot_reg;
        if (advance)
        begin
            if (req_reg)
            begin
                mode_next = MODE_IDLE;
                dot_next  = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_NUM:
                    begin
                        if (is_ws(ch_reg) || is_digit(ch_reg))
                            dot_next = dot_reg;
                        else if (ch_reg == CH_DOT && !dot_reg)
                            dot_next = 1'b1;
                        else
                        begin
                            mode_next = idle_mode;
                            dot_next  = idle_dot;
                        end
                    end
                    MODE_LDOT:
                    begin
                        if (is_ws(ch_reg))
                            dot_next = dot_reg;
                        else if (is_digit(ch_reg))
                        begin
                            mode_next = MODE_NUM;
                            dot_next  = 1'b1;
                        end
                        else
                        begin
                            mode_next = idle_mode;
                            dot_next  = idle_dot;
                        end
                    end
                    MODE_ID:
                    begin
                        if (!is_idch(ch_reg))
                        begin
                            mode_next = idle_mode;
                            dot_next  = idle_dot;
                        end
                    end
                    MODE_CMT:
                    begin
                        if (ch_reg == CH_LF)
                        begin
                            mode_next = MODE_IDLE;
                            dot_next  = 1'b0;
                        end
                    end
                    MODE_PAREN:
                    begin
                        if (ch_reg == CH_RPAREN)
                        begin
                            mode_next = MODE_IDLE;
                            dot_next  = 1'b0;
                        end
                    end
                    MODE_STAR:
                    begin
                        if (ch_reg == CH_STAR)
                        begin
                            mode_next = MODE_IDLE;
                            dot_next  = 1'b0;
                        end
                        else
                        begin
                            mode_next = idle_mode;
                            dot_next  = idle_dot;
                        end
                    end
                    default:
                    begin
                        mode_next = idle_mode;
                        dot_next  = idle_dot;
                    end
                endcase
            end
        end
    end

    // results: an optional first item from the open token, then an optional second item
    always_comb
    begin
        fv        = 1'b0;
        fr        = mk_res(TOK_NUM, CH_NUL, 1'b0, 1'b0);
        sv        = 1'b0;
        sr        = mk_res(TOK_NUM, CH_NUL, 1'b0, 1'b0);
        take_idle = 1'b0;
        if (req_reg)
        begin
            fv = 1'b1;
            unique case (mode_reg)
                MODE_NUM:   fr = mk_res(TOK_NUM, CH_NUL, 1'b0, 1'b1);
                MODE_LDOT:  fr = mk_res(TOK_DOT, CH_DOT, 1'b1, 1'b1);
                MODE_ID:    fr = mk_res(TOK_ID, CH_NUL, 1'b0, 1'b1);
                MODE_CMT:   fr = mk_res(TOK_CMT, CH_NUL, 1'b0, 1'b1);
                MODE_PAREN: fr = mk_res(TOK_ERR, CH_NUL, 1'b0, 1'b1);
                MODE_STAR:  fr = mk_res(TOK_MUL, CH_STAR, 1'b1, 1'b1);
                default:    fv = 1'b0;
            endcase
            sv = 1'b1;
            sr = mk_res(TOK_EOF, CH_NUL, 1'b0, 1'b1);
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUM:
                begin
                    if (is_ws(ch_reg))
                        fv = 1'b0;
                    else if (is_digit(ch_reg) || (ch_reg == CH_DOT && !dot_reg))
                    begin
                        fv = 1'b1;
                        fr = mk_res(TOK_NUM, ch_reg, 1'b1, 1'b0);
                    end
                    else
                    begin
                        fv        = 1'b1;
                        fr        = mk_res(TOK_NUM, CH_NUL, 1'b0, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                MODE_LDOT:
                begin
                    if (is_ws(ch_reg))
                        fv = 1'b0;
                    else if (is_digit(ch_reg))
                    begin
                        fv = 1'b1;
                        fr = mk_res(TOK_NUM, CH_DOT, 1'b1, 1'b0);
                        sv = 1'b1;
                        sr = mk_res(TOK_NUM, ch_reg, 1'b1, 1'b0);
                    end
                    else
                    begin
                        fv        = 1'b1;
                        fr        = mk_res(TOK_DOT, CH_DOT, 1'b1, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                MODE_ID:
                begin
                    fv = 1'b1;
                    if (is_idch(ch_reg))
                        fr = mk_res(TOK_ID, ch_reg, 1'b1, 1'b0);
                    else
                    begin
                        fr        = mk_res(TOK_ID, CH_NUL, 1'b0, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                MODE_CMT:
                begin
                    if (ch_reg == CH_CR)
                        fv = 1'b0;
                    else if (ch_reg == CH_LF)
                    begin
                        fv        = 1'b1;
                        fr        = mk_res(TOK_CMT, CH_NUL, 1'b0, 1'b1);
                        take_idle = 1'b1;
                    end
                    else
                    begin
                        fv = 1'b1;
                        fr = mk_res(TOK_CMT, ch_reg, 1'b1, 1'b0);
                    end
                end
                MODE_PAREN:
                begin
                    fv = 1'b1;
                    if (ch_reg == CH_RPAREN)
                        fr = mk_res(TOK_PAREN, CH_NUL, 1'b0, 1'b1);
                    else
                        fr = mk_res(TOK_PAREN, ch_reg, 1'b1, 1'b0);
                end
                MODE_STAR:
                begin
                    fv = 1'b1;
                    if (ch_reg == CH_STAR)
                    begin
                        fr = mk_res(TOK_POW, ch_reg, 1'b1, 1'b0);
                        sv = 1'b1;
                        sr = mk_res(TOK_POW, ch_reg, 1'b1, 1'b1);
                    end
                    else
                    begin
                        fr        = mk_res(TOK_MUL, CH_STAR, 1'b1, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                default: take_idle = 1'b1;
            endcase
            if (take_idle)
            begin
                sv = idle_v;
                sr = idle_r;
            end
        end
    end

    // pack so that the first valid item always sits in the first slot
    always_comb
    begin
        res.first  = fv ? fr : sr;
        res.second = sr;
        if (!advance)
            res.count = 2'd0;
        else if (fv)
            res.count = sv ? 2'd2 : 2'd1;
        else
            res.count = sv ? 2'd1 : 2'd0;
    end

endmodule

`default_nettype wire

FILE: rtl/gcode_token_lexer.sv
// a byte is held in the lexer input register, then its results enter the queue
// throughput: with out_ready high, one byte per cycle while each byte yields at
// most one result; the output port drains one result per cycle, so two-result
// bytes set the pace
// a four-entry result queue takes a byte's results once two slots are free
// reset: asynchronous, active low; lexer returns to idle and the queue empties
// ----------------------------------------------------------------------------
// gcode_token_lexer
// streaming g-code tokenizer: bytes in, token body and end items out
// ----------------------------------------------------------------------------
`default_nettype none

`include "gcode_token_lexer_assert.svh"

module gcode_token_lexer
    import gtl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] ch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      token_type,
    output logic [7:0]      value_char,
    output logic            char_valid,
    output logic            token_last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_pair_t          pair;
    logic               room;
    logic               pop;
    result_t            q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   q_count_reg, q_count_next;
    result_t            head;

    gtl_lex u_lex (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .ch       (ch),
        .room     (room),
        .res      (pair)
    );

    assign room      = q_count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = q_count_reg != '0;
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(pair.count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign q_count_next = q_count_reg + CNT_W'(pair.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.count != 2'd0)
            q_mem[wr_ptr_reg] <= pair.first;
        if (pair.count == 2'd2)
            q_mem[wr_ptr_reg + PTR_W'(1)] <= pair.second;
    end

    assign head       = q_mem[rd_ptr_reg];
    assign token_type = head.token_type;
    assign value_char = head.value_char;
    assign char_valid = head.char_valid;
    assign token_last = head.token_last;

    // a push never overruns the queue
    `GTL_ASSERT_IMPL(a_push_room, clk, rst_n, pair.count != 2'd0,
                     q_count_reg <= CNT_W'(QUEUE_DEPTH - 2))
    `GTL_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, q_count_reg <= CNT_W'(QUEUE_DEPTH))
    // a two-item push that keeps its first token open stays in that token
    `GTL_ASSERT_IMPL(a_pair_order, clk, rst_n,
                     pair.count == 2'd2 && !pair.first.token_last,
                     pair.second.token_type == pair.first.token_type)
    // occupancy and pointers stay consistent
    `GTL_ASSERT_NEXT(a_ptr_track, clk, rst_n, 1'b1,
                     q_count_reg[PTR_W-1:0] == PTR_W'(wr_ptr_reg - rd_ptr_reg))

endmodule

`default_nettype wire

FILE: sim/tb_gcode_token_lexer.sv
// ----------------------------------------------------------------------------
// tb_gcode_token_lexer
// self-checking bench: feeds g-code bytes and end-of-input items through the
// valid/ready input, predicts the token stream in a scoreboard class and
// checks every output transfer against it, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_gcode_token_lexer;
    import gtl_pkg::*;

    localparam int         TOTAL_ITEMS  = 1430;
    localparam int         HOLD_AT      = 400;
    localparam int         PAUSE_AT     = 800;
    localparam int         QUIET_AT     = 1200;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_LIMIT  = 2000;
    localparam int         TAIL_CYCLES  = 20;
    localparam logic [8:0] END_OF_INPUT = 9'h100;

    // ------------------------------------------------------------------------
    // token stream scoreboard
    // ------------------------------------------------------------------------
    class token_scoreboard;
        localparam int PRINT_CAP = 100;

        lex_mode_t mode;
        bit        in_dot;
        int        made;
        int        errors;
        result_t   token_q[$];

        function new();
            mode   = MODE_IDLE;
            in_dot = 1'b0;
            made   = 0;
            errors = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
        endfunction

        function bit is_numeral(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit is_word_ch(logic [7:0] c);
            return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
                || (c == CH_UNDER);
        endfunction

        function void emit_item(tok_t t, logic [7:0] c, bit v, bit l);
            result_t r;
            // one byte never yields more than two items
            if (made >= 2)
                return;
            r.token_type = t;
            r.value_char = v ? c : 8'h00;
            r.char_valid = v;
            r.token_last = l;
            token_q.push_back(r);
            made++;
        endfunction

        // byte seen while between tokens
        function void lex_fresh(logic [7:0] c);
            mode   = MODE_IDLE;
            in_dot = 1'b0;
            if (is_blank(c) || (c == CH_PCT))
                return;
            if (c == CH_NUL)
            begin
                emit_item(TOK_EOF, 8'h00, 1'b0, 1'b1);
                return;
            end
            if (c == CH_SEMI)
            begin
                mode = MODE_CMT;
                return;
            end
            if (c == CH_LPAREN)
            begin
                mode = MODE_PAREN;
                return;
            end
            if (c == CH_DOT)
            begin
                mode   = MODE_LDOT;
                in_dot = 1'b1;
                return;
            end
            if (is_numeral(c))
            begin
                emit_item(TOK_NUM, c, 1'b1, 1'b0);
                mode = MODE_NUM;
                return;
            end
            if (is_word_ch(c))
            begin
                emit_item(TOK_ID, c, 1'b1, 1'b0);
                mode = MODE_ID;
                return;
            end
            if (c == CH_STAR)
            begin
                mode = MODE_STAR;
                return;
            end
            case (c)
                CH_PLUS:  emit_item(TOK_ADD, c, 1'b1, 1'b1);
                CH_MINUS: emit_item(TOK_SUB, c, 1'b1, 1'b1);
                CH_SLASH: emit_item(TOK_DIV, c, 1'b1, 1'b1);
                CH_LBRK:  emit_item(TOK_OBR, c, 1'b1, 1'b1);
                CH_RBRK:  emit_item(TOK_CBR, c, 1'b1, 1'b1);
                CH_LT:    emit_item(TOK_OANG, c, 1'b1, 1'b1);
                CH_GT:    emit_item(TOK_CANG, c, 1'b1, 1'b1);
                CH_EQ:    emit_item(TOK_EQ, c, 1'b1, 1'b1);
                CH_POUND: emit_item(TOK_POUND, c, 1'b1, 1'b1);
                CH_LF:    emit_item(TOK_EOL, c, 1'b1, 1'b1);
                default:  emit_item(TOK_ERR, c, 1'b1, 1'b1);
            endcase
        endfunction

        function void note_input(logic rt, logic [7:0] c);
            made = 0;
            if (rt)
            begin
                case (mode)
                    MODE_NUM:   emit_item(TOK_NUM, 8'h00, 1'b0, 1'b1);
                    MODE_LDOT:  emit_item(TOK_DOT, CH_DOT, 1'b1, 1'b1);
                    MODE_ID:    emit_item(TOK_ID, 8'h00, 1'b0, 1'b1);
                    MODE_CMT:   emit_item(TOK_CMT, 8'h00, 1'b0, 1'b1);
                    MODE_PAREN: emit_item(TOK_ERR, 8'h00, 1'b0, 1'b1);
                    MODE_STAR:  emit_item(TOK_MUL, CH_STAR, 1'b1, 1'b1);
                    default:    ;
                endcase
                emit_item(TOK_EOF, 8'h00, 1'b0, 1'b1);
                mode   = MODE_IDLE;
                in_dot = 1'b0;
                return;
            end
            case (mode)
                MODE_NUM:
                begin
                    if (is_blank(c))
                        return;
                    if (is_numeral(c))
                        emit_item(TOK_NUM, c, 1'b1, 1'b0);
                    else if ((c == CH_DOT) && !in_dot)
                    begin
                        emit_item(TOK_NUM, c, 1'b1, 1'b0);
                        in_dot = 1'b1;
                    end
                    else
                    begin
                        emit_item(TOK_NUM, 8'h00, 1'b0, 1'b1);
                        lex_fresh(c);
                    end
                end
                MODE_LDOT:
                begin
                    if (is_blank(c))
                        return;
                    if (is_numeral(c))
                    begin
                        emit_item(TOK_NUM, CH_DOT, 1'b1, 1'b0);
                        emit_item(TOK_NUM, c, 1'b1, 1'b0);
                        mode   = MODE_NUM;
                        in_dot = 1'b1;
                    end
                    else
                    begin
                        emit_item(TOK_DOT, CH_DOT, 1'b1, 1'b1);
                        lex_fresh(c);
                    end
                end
                MODE_ID:
                begin
                    if (is_word_ch(c))
                        emit_item(TOK_ID, c, 1'b1, 1'b0);
                    else
                    begin
                        emit_item(TOK_ID, 8'h00, 1'b0, 1'b1);
                        lex_fresh(c);
                    end
                end
                MODE_CMT:
                begin
                    if (c == CH_CR)
                        return;
                    if (c == CH_LF)
                    begin
                        emit_item(TOK_CMT, 8'h00, 1'b0, 1'b1);
                        lex_fresh(c);
                    end
                    else
                        emit_item(TOK_CMT, c, 1'b1, 1'b0);
                end
                MODE_PAREN:
                begin
                    if (c == CH_RPAREN)
                    begin
                        emit_item(TOK_PAREN, 8'h00, 1'b0, 1'b1);
                        mode   = MODE_IDLE;
                        in_dot = 1'b0;
                    end
                    else
                        emit_item(TOK_PAREN, c, 1'b1, 1'b0);
                end
                MODE_STAR:
                begin
                    if (c == CH_STAR)
                    begin
                        emit_item(TOK_POW, c, 1'b1, 1'b0);
                        emit_item(TOK_POW, c, 1'b1, 1'b1);
                        mode   = MODE_IDLE;
                        in_dot = 1'b0;
                    end
                    else
                    begin
                        emit_item(TOK_MUL, CH_STAR, 1'b1, 1'b1);
                        lex_fresh(c);
                    end
                end
                default:
                    lex_fresh(c);
            endcase
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [4:0] tt, logic [7:0] vc, logic cv, logic tl);
            result_t want;
            if (token_q.size() == 0)
            begin
                report($sformatf("unexpected item type %0d char %02h valid %b last %b",
                                 tt, vc, cv, tl));
                return;
            end
            want = token_q.pop_front();
            if ((tt !== want.token_type) || (vc !== want.value_char)
                || (cv !== want.char_valid) || (tl !== want.token_last))
                report($sformatf("got type %0d char %02h valid %b last %b, want %0d %02h %b %b",
                                 tt, vc, cv, tl, want.token_type, want.value_char,
                                 want.char_valid, want.token_last));
        endtask

        function int pending();
            return token_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid;
    logic       in_ready;
    logic       req_type;
    logic [7:0] ch;
    logic       out_valid;
    logic       out_ready;
    logic [4:0] token_type;
    logic [7:0] value_char;
    logic       char_valid;
    logic       token_last;

    token_scoreboard sb;
    logic [8:0]      text_q[$];
    int              sent_cnt  = 0;
    int              cycle_cnt = 0;
    bit              quiet     = 1'b0;
    bit              calm      = 1'b0;
    bit              hold_req  = 1'b0;

    gcode_token_lexer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .token_type (token_type),
        .value_char (value_char),
        .char_valid (char_valid),
        .token_last (token_last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // text building
    // ------------------------------------------------------------------------
    function automatic void put_ch(logic [7:0] c);
        text_q.push_back({1'b0, c});
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_ch(s[i]);
    endfunction

    function automatic void put_digits(int n);
        for (int i = 0; i < n; i++)
        begin
            put_ch(8'("0" + $urandom_range(0, 9)));
            // blanks are skipped inside numbers
            if ((i < n - 1) && ($urandom_range(0, 7) == 0))
                put_ch($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 3) == 0)
            put_ch(CH_MINUS);
        if ($urandom_range(0, 5) == 0)
        begin
            put_ch(CH_DOT);
            put_digits($urandom_range(1, 3));
            return;
        end
        put_digits($urandom_range(1, 4));
        if ($urandom_range(0, 1) == 0)
        begin
            put_ch(CH_DOT);
            put_digits($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
            begin
                put_ch(CH_DOT);
                put_digits($urandom_range(0, 2));
            end
        end
    endfunction

    function automatic void put_name();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 4))
                0:       put_ch(CH_UNDER);
                1, 2:    put_ch(8'("a" + $urandom_range(0, 25)));
                default: put_ch(8'("A" + $urandom_range(0, 25)));
            endcase
        end
    endfunction

    function automatic void put_text(bit paren);
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h20, 8'h7e));
            if (paren && (c == CH_RPAREN))
                c = CH_LPAREN;
            if (!paren && (c == CH_LF))
                c = CH_CR;
            put_ch(c);
        end
    endfunction

    function automatic void put_line();
        int pieces;
        pieces = $urandom_range(1, 5);
        for (int i = 0; i < pieces; i++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3:
                begin
                    put_ch($urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                                : 8'("a" + $urandom_range(0, 25)));
                    put_number();
                end
                4:
                begin
                    put_ch(CH_LBRK);
                    put_ch(CH_POUND);
                    put_number();
                    case ($urandom_range(0, 4))
                        0: put_ch(CH_PLUS);
                        1: put_ch(CH_MINUS);
                        2: put_ch(CH_SLASH);
                        3: put_ch(CH_STAR);
                        default: put_str("**");
                    endcase
                    put_number();
                    put_ch(CH_RBRK);
                end
                5:
                begin
                    put_ch(CH_LT);
                    put_name();
                    put_ch(CH_GT);
                end
                6:
                begin
                    put_ch(CH_POUND);
                    put_digits($urandom_range(1, 3));
                    put_ch(CH_EQ);
                    put_number();
                end
                7:
                begin
                    put_ch(CH_LPAREN);
                    put_text(1'b1);
                    put_ch(CH_RPAREN);
                end
                8:  put_ch(CH_TAB);
                9:  put_ch(CH_PCT);
                default: put_name();
            endcase
            if ($urandom_range(0, 1) == 0)
                put_ch(CH_SPACE);
        end
        case ($urandom_range(0, 3))
            0:
            begin
                put_ch(CH_SEMI);
                put_text(1'b0);
                put_str("\r\n");
            end
            1:       put_str("\r\n");
            default: put_ch(CH_LF);
        endcase
    endfunction

    // garbage and broken constructs
    function automatic void put_noise();
        int n;
        case ($urandom_range(0, 6))
            0, 1:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    put_ch(8'($urandom_range(0, 255)));
            end
            2:
            begin
                put_ch(CH_LPAREN);
                put_text(1'b1);
                text_q.push_back(END_OF_INPUT);
            end
            3:
            begin
                put_ch(CH_STAR);
                text_q.push_back(END_OF_INPUT);
            end
            4:
            begin
                put_ch(CH_DOT);
                text_q.push_back(END_OF_INPUT);
            end
            5:
            begin
                put_ch(CH_NUL);
                put_name();
                text_q.push_back(END_OF_INPUT);
            end
            default:
            begin
                put_number();
                text_q.push_back(END_OF_INPUT);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_item(input logic rt, input logic [7:0] c);
        in_valid <= 1'b1;
        req_type <= rt;
        ch       <= c;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(rt, c);
        sent_cnt++;
        if (!quiet && !calm && ($urandom_range(0, 5) == 0))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic flush_text();
        logic [8:0] e;
        while (text_q.size() != 0)
        begin
            e = text_q.pop_front();
            if (e[8])
                send_item(1'b1, 8'($urandom_range(0, 255)));
            else
                send_item(1'b0, e[7:0]);
        end
    endtask

    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        while ((sb.pending() != 0) && (waited < limit))
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------
    initial
    begin : rx_side
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long stall so the result queue fills and input backs up
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && !calm && ($urandom_range(0, 6) == 0))
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(token_type, value_char, char_valid, token_last);
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stim
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();
        in_valid <= 1'b0;
        req_type <= 1'b0;
        ch       <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // second dot, lone dot before a digit and before a letter, pow, mul
        put_str("9.1.0.7._**");
        put_str("*-");
        // semicolon comment drops cr, newline closes it then gives eol
        put_str(";a\r\n");
        // paren body keeps zero and newline
        put_ch(CH_LPAREN);
        put_ch(CH_NUL);
        put_ch(CH_LF);
        put_ch(CH_RPAREN);
        put_ch(8'hff);
        put_ch(CH_PCT);
        put_ch(CH_NUL);
        // end of input inside a paren comment and after a lone star
        put_ch(CH_LPAREN);
        text_q.push_back(END_OF_INPUT);
        put_ch(CH_STAR);
        text_q.push_back(END_OF_INPUT);
        flush_text();

        while (sent_cnt < TOTAL_ITEMS)
        begin
            if (!hold_done && (sent_cnt >= HOLD_AT))
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!pause_done && (sent_cnt >= PAUSE_AT))
            begin
                pause_done = 1'b1;
                in_valid <= 1'b0;
                wait_drained(DRAIN_LIMIT);
                @(posedge clk);
            end
            if (sent_cnt >= QUIET_AT)
                quiet = 1'b1;
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0)
                put_noise();
            else
                put_line();
            flush_text();
        end
        in_valid <= 1'b0;

        wait_drained(DRAIN_LIMIT);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d token items never arrived", sb.pending()));
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
